>>> rtl/core/ppmp6_pkg.sv
// Package: shared types and constants of the PPM P6 stream parser.
package ppmp6_pkg;

    // Header characters
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_SIX  = 8'h36;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Maximum sample value register width, saturates at all ones
    localparam int MAXV_BITS = 16;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PIXEL     = 3'd0,
        KIND_HEADER    = 3'd1,
        KIND_BAD_MAGIC = 3'd2,
        KIND_EXCESS    = 3'd3,
        KIND_END       = 3'd4
    } t_kind;

    // Parser phases, one-hot
    typedef enum logic [7:0] {
        PH_MAGIC0 = 8'b0000_0001,
        PH_MAGIC1 = 8'b0000_0010,
        PH_SKIP   = 8'b0000_0100,
        PH_WIDTH  = 8'b0000_1000,
        PH_HEIGHT = 8'b0001_0000,
        PH_MAXV   = 8'b0010_0000,
        PH_PIXEL  = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } t_phase;

    // One result transaction
    typedef struct packed {
        t_kind        kind;
        logic [15:0]  pixel_x;
        logic [15:0]  pixel_y;
        logic [31:0]  pixel_index;
        logic [23:0]  pixel_word;
        logic [15:0]  image_width;
        logic [15:0]  image_height;
        logic [15:0]  max_value;
        logic         end_of_image;
    } t_result;

endpackage

>>> rtl/core/ppmp6_ifs.sv
// Interfaces: byte input channel and result output channel.
interface ppmp6_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppmp6_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [31:0] pixel_index;
    logic [23:0] pixel_word;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] max_value;
    logic        end_of_image;

    modport source (
        output valid, output kind, output pixel_x, output pixel_y, output pixel_index,
        output pixel_word, output image_width, output image_height, output max_value,
        output end_of_image, input ready
    );
    modport sink (
        input valid, input kind, input pixel_x, input pixel_y, input pixel_index,
        input pixel_word, input image_width, input image_height, input max_value,
        input end_of_image, output ready
    );
endinterface

>>> rtl/core/ppmp6_parse.sv
// Parser core: header/pixel state, one byte per step, combinational result.
module ppmp6_parse #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output logic                o_emit,
    output ppmp6_pkg::t_result  o_res
);

    localparam int PW = 2 * DIM_BITS;

    ppmp6_pkg::t_phase     r_phase, w_phase, n_phase;
    logic [DIM_BITS-1:0]   r_width, w_width, n_width;
    logic [DIM_BITS-1:0]   r_height, w_height, n_height;
    logic [ppmp6_pkg::MAXV_BITS-1:0] r_maxv, w_maxv, n_maxv;
    logic [1:0]            r_byte_cnt, w_byte_cnt, n_byte_cnt;
    logic [7:0]            r_red, w_red, n_red;
    logic [7:0]            r_green, w_green, n_green;
    logic [DIM_BITS-1:0]   r_col, w_col, n_col;
    logic [DIM_BITS-1:0]   r_row, w_row, n_row;

    logic                  w_is_digit;
    logic [3:0]            w_digit;
    logic [DIM_BITS-1:0]   w_dim_src;
    logic [DIM_BITS+3:0]   w_dim_mac;
    logic [DIM_BITS-1:0]   w_dim_sat;
    logic [ppmp6_pkg::MAXV_BITS+3:0] w_maxv_mac;
    logic [ppmp6_pkg::MAXV_BITS-1:0] w_maxv_sat;
    logic [PW-1:0]         w_prod;
    logic [PW+31:0]        w_prod_ext;
    logic [DIM_BITS+31:0]  w_col_ext;
    logic [31:0]           w_index;
    logic [DIM_BITS:0]     w_col_inc;
    logic                  w_wrap;
    logic                  w_excess;
    logic                  w_have;
    ppmp6_pkg::t_kind      w_kind;
    logic [DIM_BITS+15:0]  w_x_ext, w_y_ext, w_w_ext, w_h_ext;

    // Digit decode
    always_comb begin
        w_is_digit = (i_data_byte inside {[ppmp6_pkg::CHAR_ZERO:ppmp6_pkg::CHAR_NINE]});
        w_digit    = 4'(i_data_byte - ppmp6_pkg::CHAR_ZERO);
    end

    // Decimal accumulate with saturation: acc * 10 + digit
    always_comb begin
        w_dim_src  = (r_phase == ppmp6_pkg::PH_WIDTH) ? r_width : r_height;
        w_dim_mac  = ({4'b0, w_dim_src} << 3) + ({4'b0, w_dim_src} << 1)
                   + (DIM_BITS+4)'(w_digit);
        w_dim_sat  = (|w_dim_mac[DIM_BITS+3:DIM_BITS]) ? '1 : w_dim_mac[DIM_BITS-1:0];
        w_maxv_mac = ({4'b0, r_maxv} << 3) + ({4'b0, r_maxv} << 1)
                   + (ppmp6_pkg::MAXV_BITS+4)'(w_digit);
        w_maxv_sat = (|w_maxv_mac[ppmp6_pkg::MAXV_BITS+3:ppmp6_pkg::MAXV_BITS]) ?
                     '1 : w_maxv_mac[ppmp6_pkg::MAXV_BITS-1:0];
    end

    // Pixel position: index = col + row * width, modulo 2^32
    always_comb begin
        w_prod     = PW'(r_row) * PW'(r_width);
        w_prod_ext = {32'b0, w_prod};
        w_col_ext  = {32'b0, r_col};
        w_index    = w_prod_ext[31:0] + w_col_ext[31:0];
        w_col_inc  = {1'b0, r_col} + 1'b1;
        w_wrap     = (w_col_inc >= {1'b0, r_width});
        w_excess   = (r_row >= r_height);
    end

    // Phase sequencing
    always_comb begin
        w_phase    = r_phase;
        w_width    = r_width;
        w_height   = r_height;
        w_maxv     = r_maxv;
        w_byte_cnt = r_byte_cnt;
        w_red      = r_red;
        w_green    = r_green;
        w_col      = r_col;
        w_row      = r_row;
        w_have     = 1'b0;
        w_kind     = ppmp6_pkg::KIND_END;
        case (r_phase)
            ppmp6_pkg::PH_MAGIC0: begin
                if (i_data_byte == ppmp6_pkg::CHAR_P) begin
                    w_phase = ppmp6_pkg::PH_MAGIC1;
                end else begin
                    w_phase = ppmp6_pkg::PH_ERROR;
                    w_kind  = ppmp6_pkg::KIND_BAD_MAGIC;
                    w_have  = 1'b1;
                end
            end
            ppmp6_pkg::PH_MAGIC1: begin
                if (i_data_byte == ppmp6_pkg::CHAR_SIX) begin
                    w_phase = ppmp6_pkg::PH_SKIP;
                end else begin
                    w_phase = ppmp6_pkg::PH_ERROR;
                    w_kind  = ppmp6_pkg::KIND_BAD_MAGIC;
                    w_have  = 1'b1;
                end
            end
            ppmp6_pkg::PH_SKIP: begin
                w_phase = ppmp6_pkg::PH_WIDTH;
            end
            ppmp6_pkg::PH_WIDTH: begin
                if (w_is_digit) w_width = w_dim_sat;
                else            w_phase = ppmp6_pkg::PH_HEIGHT;
            end
            ppmp6_pkg::PH_HEIGHT: begin
                if (w_is_digit) w_height = w_dim_sat;
                else            w_phase  = ppmp6_pkg::PH_MAXV;
            end
            ppmp6_pkg::PH_MAXV: begin
                if (w_is_digit) begin
                    w_maxv = w_maxv_sat;
                end else begin
                    w_phase = ppmp6_pkg::PH_PIXEL;
                    w_kind  = ppmp6_pkg::KIND_HEADER;
                    w_have  = 1'b1;
                end
            end
            ppmp6_pkg::PH_PIXEL: begin
                if (r_byte_cnt == 2'd0) begin
                    w_red      = i_data_byte;
                    w_byte_cnt = 2'd1;
                end else if (r_byte_cnt == 2'd1) begin
                    w_green    = i_data_byte;
                    w_byte_cnt = 2'd2;
                end else begin
                    w_byte_cnt = 2'd0;
                    w_have     = 1'b1;
                    w_kind     = w_excess ? ppmp6_pkg::KIND_EXCESS : ppmp6_pkg::KIND_PIXEL;
                    if (w_wrap) begin
                        w_col = '0;
                        if (r_row != '1) w_row = r_row + 1'b1;
                    end else begin
                        w_col = w_col_inc[DIM_BITS-1:0];
                    end
                end
            end
            default: begin
                // error phase: bytes ignored until the last one
            end
        endcase
    end

    // Last byte rearms the parser
    always_comb begin
        if (i_last_byte) begin
            n_phase    = ppmp6_pkg::PH_MAGIC0;
            n_width    = '0;
            n_height   = '0;
            n_maxv     = '0;
            n_byte_cnt = '0;
            n_red      = '0;
            n_green    = '0;
            n_col      = '0;
            n_row      = '0;
        end else begin
            n_phase    = w_phase;
            n_width    = w_width;
            n_height   = w_height;
            n_maxv     = w_maxv;
            n_byte_cnt = w_byte_cnt;
            n_red      = w_red;
            n_green    = w_green;
            n_col      = w_col;
            n_row      = w_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ppmp6_pkg::PH_MAGIC0;
            r_width    <= '0;
            r_height   <= '0;
            r_maxv     <= '0;
            r_byte_cnt <= '0;
            r_red      <= '0;
            r_green    <= '0;
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_width    <= n_width;
            r_height   <= n_height;
            r_maxv     <= n_maxv;
            r_byte_cnt <= n_byte_cnt;
            r_red      <= n_red;
            r_green    <= n_green;
            r_col      <= n_col;
            r_row      <= n_row;
        end
    end

    // Result fields; pixel data only on a pixel result
    always_comb begin
        w_x_ext = {16'b0, r_col};
        w_y_ext = {16'b0, r_row};
        w_w_ext = {16'b0, w_width};
        w_h_ext = {16'b0, w_height};
        o_emit  = w_have || i_last_byte;
        o_res.kind         = w_kind;
        o_res.pixel_x      = '0;
        o_res.pixel_y      = '0;
        o_res.pixel_index  = '0;
        o_res.pixel_word   = '0;
        if (w_have && (w_kind == ppmp6_pkg::KIND_PIXEL)) begin
            o_res.pixel_x     = w_x_ext[15:0];
            o_res.pixel_y     = w_y_ext[15:0];
            o_res.pixel_index = w_index;
            o_res.pixel_word  = {i_data_byte, r_green, r_red};
        end
        o_res.image_width  = w_w_ext[15:0];
        o_res.image_height = w_h_ext[15:0];
        o_res.max_value    = w_maxv;
        o_res.end_of_image = i_last_byte;
    end

`ifndef SYNTHESIS
    // The last byte leaves the parser in its reset state
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last_byte) |=> (r_phase == ppmp6_pkg::PH_MAGIC0 && r_byte_cnt == 2'd0
                                     && r_col == '0 && r_row == '0 && r_width == '0))
        else $error("parser not rearmed after last byte");

    // Partial pixel bytes only exist in the pixel phase
    a_cnt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_cnt != 2'd0) |-> (r_phase == ppmp6_pkg::PH_PIXEL && r_byte_cnt != 2'd3))
        else $error("pixel byte count outside pixel phase");

    // Column stays inside the image width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width != '0) |-> (r_col < r_width))
        else $error("column beyond width");

    // A pixel result is only given for a row inside the image
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_have && w_kind == ppmp6_pkg::KIND_PIXEL) |-> (r_row < r_height))
        else $error("pixel emitted past image height");
`endif

endmodule

>>> rtl/core/ppm_p6_stream_parser.sv
// Top level: PPM P6 byte stream parser with input and result registers.
//
//  channel | dir | modport     | payload
//  i_in    | in  | sink        | data_byte[7:0], last_byte
//  o_out   | out | source      | kind, pixel_x/y, pixel_index, pixel_word,
//          |     |             | image_width/height, max_value, end_of_image
//
// One byte per cycle sustained while no result is blocked; a taken byte goes to the input
// register, then through the parse step into the result register.
// The parse step holds the decimal multiply-by-ten and the row * width product.
// Reset is synchronous, active low, and clears all control state.
// A stalled result holds the output register; the input register keeps taking
// bytes that cause no result, and stops only when a result is blocked.
module ppm_p6_stream_parser #(
    parameter int DIM_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ppmp6_in_if.sink           i_in,
    ppmp6_out_if.source        o_out
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;
    logic                r_out_valid;
    ppmp6_pkg::t_result  r_out;

    logic                w_emit;
    logic                w_out_free;
    logic                w_step;
    ppmp6_pkg::t_result  w_res;

    // A held byte advances when its result, if any, has a free slot
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && (w_out_free || !w_emit);
    assign i_in.ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    ppmp6_parse #(
        .DIM_BITS (DIM_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_emit      (w_emit),
        .o_res       (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_step && w_emit) begin
            r_out <= w_res;
        end
    end

    // Output channel
    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.pixel_x      = r_out.pixel_x;
    assign o_out.pixel_y      = r_out.pixel_y;
    assign o_out.pixel_index  = r_out.pixel_index;
    assign o_out.pixel_word   = r_out.pixel_word;
    assign o_out.image_width  = r_out.image_width;
    assign o_out.image_height = r_out.image_height;
    assign o_out.max_value    = r_out.max_value;
    assign o_out.end_of_image = r_out.end_of_image;

endmodule
